>>> src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_LONE_CHAR = 2'd1;
  localparam logic [1:0] STATUS_PAD_ERR   = 2'd2;
  localparam logic [1:0] STATUS_AFTER_PAD = 2'd3;

  typedef struct packed {
    logic       is_pad;
    logic [5:0] sextet;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    s = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 6'd62;
    end else if (c == 8'h2F) begin
      s = 6'd63;
    end
    return s;
  endfunction

endpackage

>>> src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input characters and registers them as classified beats.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  input  b64d_pkg::queue_stat_t q_stat,
  output logic                  push,
  output b64d_pkg::beat_t       push_beat
);

  logic            f_valid;
  b64d_pkg::beat_t f_beat;

  assign in_stall  = f_valid && q_stat.full;
  assign push      = f_valid && !q_stat.full;
  assign push_beat = f_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_beat.is_pad <= (char_code == b64d_pkg::PAD_CHAR);
      f_beat.sextet <= b64d_pkg::sextet_of(char_code);
      f_beat.last   <= last_char;
    end
  end

endmodule

>>> src/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of classified beats between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64d_pkg::beat_t       push_beat,
  input  logic                  pop,
  output b64d_pkg::beat_t       head,
  output b64d_pkg::queue_stat_t q_stat
);

  b64d_pkg::beat_t                  entries [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [b64d_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [b64d_pkg::QUEUE_AW:0]      count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == (b64d_pkg::QUEUE_AW + 1)'(b64d_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

endmodule

>>> src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Decodes queued beats into bytes, tracks padding and status, and holds
// the output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64d_pkg::beat_t       head,
  input  b64d_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  byte_valid,
  output logic [7:0]            out_byte,
  output logic                  end_of_text,
  output logic [1:0]            status
);

  logic [1:0] group_position;
  logic [5:0] prior_sextet;
  logic [1:0] pad_count;
  logic [1:0] sticky_status;

  logic [1:0] group_position_next;
  logic [5:0] prior_sextet_next;
  logic [1:0] pad_count_next;
  logic [1:0] sticky_status_next;
  logic       byte_valid_next;
  logic [7:0] out_byte_next;
  logic [1:0] status_next;
  logic [5:0] s;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);
  assign s   = head.sextet;

  always_comb begin
    group_position_next = group_position;
    prior_sextet_next   = prior_sextet;
    pad_count_next      = pad_count;
    sticky_status_next  = sticky_status;
    byte_valid_next     = 1'b0;
    out_byte_next       = 8'd0;
    status_next         = b64d_pkg::STATUS_OK;
    if (head.is_pad) begin
      if (pad_count != 2'd3) begin
        pad_count_next = pad_count + 2'd1;
      end
    end else begin
      if (pad_count != 2'd0) begin
        sticky_status_next = b64d_pkg::STATUS_AFTER_PAD;
      end
      case (group_position)
        2'd0: begin
          prior_sextet_next   = s;
          group_position_next = 2'd1;
        end
        2'd1: begin
          out_byte_next       = {prior_sextet, s[5:4]};
          prior_sextet_next   = {2'b00, s[3:0]};
          group_position_next = 2'd2;
          byte_valid_next     = 1'b1;
        end
        2'd2: begin
          out_byte_next       = {prior_sextet[3:0], s[5:2]};
          prior_sextet_next   = {4'b0000, s[1:0]};
          group_position_next = 2'd3;
          byte_valid_next     = 1'b1;
        end
        default: begin
          out_byte_next       = {prior_sextet[1:0], s};
          prior_sextet_next   = 6'd0;
          group_position_next = 2'd0;
          byte_valid_next     = 1'b1;
        end
      endcase
    end
    if (head.last) begin
      if (sticky_status_next != b64d_pkg::STATUS_OK) begin
        status_next = sticky_status_next;
      end else begin
        case (group_position_next)
          2'd1: status_next = b64d_pkg::STATUS_LONE_CHAR;
          2'd2: status_next = (pad_count_next == 2'd2) ? b64d_pkg::STATUS_OK
                                                       : b64d_pkg::STATUS_PAD_ERR;
          2'd3: status_next = (pad_count_next == 2'd1) ? b64d_pkg::STATUS_OK
                                                       : b64d_pkg::STATUS_PAD_ERR;
          default: status_next = (pad_count_next == 2'd0) ? b64d_pkg::STATUS_OK
                                                          : b64d_pkg::STATUS_PAD_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      prior_sextet   <= 6'd0;
      pad_count      <= 2'd0;
      sticky_status  <= b64d_pkg::STATUS_OK;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.last) begin
          group_position <= 2'd0;
          prior_sextet   <= 6'd0;
          pad_count      <= 2'd0;
          sticky_status  <= b64d_pkg::STATUS_OK;
        end else begin
          group_position <= group_position_next;
          prior_sextet   <= prior_sextet_next;
          pad_count      <= pad_count_next;
          sticky_status  <= sticky_status_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_valid  <= byte_valid_next;
      out_byte    <= out_byte_next;
      end_of_text <= head.last;
      status      <= status_next;
    end
  end

endmodule

>>> src/base64_decoder_stream_unit.sv
// A character passes the front register, a queue entry and the output register.
// Throughput: one character per cycle while out_stall stays low.
// Reset: synchronous rst clears the decode state, the queue and both valids.
// ----------------------------------------------------------------------------
// base64_decoder_stream_unit
// Streaming base64 decoder: one character in, one result beat out.
// ----------------------------------------------------------------------------
module base64_decoder_stream_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_valid,
  output logic [7:0] out_byte,
  output logic       end_of_text,
  output logic [1:0] status
);

  b64d_pkg::queue_stat_t q_stat;
  b64d_pkg::beat_t       push_beat;
  b64d_pkg::beat_t       head;
  logic                  push;
  logic                  pop;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_stat    (q_stat),
    .push      (push),
    .push_beat (push_beat)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_valid  (byte_valid),
    .out_byte    (out_byte),
    .end_of_text (end_of_text),
    .status      (status)
  );

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("out_byte nonzero without a decoded byte");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_text |-> status == b64d_pkg::STATUS_OK)
    else $error("status nonzero before end of text");

  a_queue_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_stat.empty && !push)
    else $error("queue pushed while full");

endmodule
